>>> hdl/rts_pkg.sv
// Package for the readability text statistics block.
// Holds payload structs, character codes, scoring constants and the
// controller/datapath command and status structs. No dependencies.
package rts_pkg;

    localparam int COUNT_BITS = 32;
    localparam int RUNS_BITS  = 16;
    localparam int QUO_BITS   = COUNT_BITS + 16;

    localparam logic [7:0] CHAR_PERIOD = 8'h2E;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_A      = 8'h61;
    localparam logic [7:0] CHAR_E      = 8'h65;
    localparam logic [7:0] CHAR_I      = 8'h69;
    localparam logic [7:0] CHAR_O      = 8'h6F;
    localparam logic [7:0] CHAR_U      = 8'h75;
    localparam logic [7:0] CHAR_Y      = 8'h79;

    localparam logic [19:0] K_WPS = 20'd25559;
    localparam logic [19:0] K_SPW = 20'd773325;
    localparam logic signed [33:0] K_OFS = 34'sd1021706;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [31:0]        sentence_total;
        logic [31:0]        word_total;
        logic [31:0]        scored_word_total;
        logic [31:0]        syllable_total;
        logic [31:0]        words_per_sentence;
        logic [31:0]        syllables_per_word;
        logic signed [31:0] grade_score;
        logic               divide_fault;
    } out_item_t;

    // Controller to datapath.
    typedef struct packed {
        logic take_byte;    // apply one byte to the counters
        logic close_text;   // close open word and segment
        logic div_start;    // load the divider for one average
        logic div_sel;      // 0: words/sentence, 1: syllables/word
        logic div_step;     // one restoring division step
        logic div_store;    // keep the finished quotient
        logic score_mul;    // form the two products
        logic score_fin;    // sum, offset, saturate; load result
        logic clear;        // return counters to reset values
    } rts_cmd_t;

    typedef struct packed {
        logic div_done;
    } rts_sts_t;

endpackage

>>> hdl/rts_datapath.sv
// Datapath: text counters, shared bit-serial divider and score arithmetic.
// Depends on rts_pkg.
module rts_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  rts_pkg::in_item_t   in_item,
    input  rts_pkg::rts_cmd_t   cmd,
    output rts_pkg::rts_sts_t   sts,
    output rts_pkg::out_item_t  result
);
    localparam int CB = rts_pkg::COUNT_BITS;
    localparam int QB = rts_pkg::QUO_BITS;
    localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};
    localparam logic [rts_pkg::RUNS_BITS-1:0] RUNS_MAX = {rts_pkg::RUNS_BITS{1'b1}};
    localparam int DCW = $clog2(QB + 1);

    logic [CB-1:0] sent_reg, word_reg, scored_reg, syl_reg;
    logic [CB-1:0] sent_next, word_next, scored_next, syl_next;
    logic seg_reg, inw_reg, prevv_reg, laste_reg, lastop_reg;
    logic seg_next, inw_next, prevv_next, laste_next, lastop_next;
    logic [1:0] vseen_reg, vseen_next;
    logic [rts_pkg::RUNS_BITS-1:0] runs_reg, runs_next;

    // Divider state.
    logic [QB-1:0] dnum_reg;
    logic [CB:0]   drem_reg;
    logic [CB-1:0] dden_reg;
    logic [DCW-1:0] dcnt_reg;
    logic [31:0] wps_reg, spw_reg;
    rts_pkg::out_item_t result_reg;

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] a,
                                              input logic [CB-1:0] b);
        logic [CB:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_inc = (s[CB] || s[CB-1:0] == CNT_MAX) ? CNT_MAX : s[CB-1:0];
        end
    endfunction

    function automatic logic [31:0] sat32(input logic [CB-1:0] v);
        begin
            sat32 = (CB > 32 && (v >> 32) != '0) ? 32'hFFFF_FFFF : 32'(v);
        end
    endfunction

    logic [7:0] c;
    logic       is_vowel;
    logic [rts_pkg::RUNS_BITS-1:0] syl;
    logic close_w, close_s;

    always_comb
    begin
        c = in_item.text_byte;
        is_vowel = (c == rts_pkg::CHAR_A) || (c == rts_pkg::CHAR_E) ||
                   (c == rts_pkg::CHAR_I) || (c == rts_pkg::CHAR_O) ||
                   (c == rts_pkg::CHAR_U) || (c == rts_pkg::CHAR_Y);
        sent_next = sent_reg; word_next = word_reg;
        scored_next = scored_reg; syl_next = syl_reg;
        seg_next = seg_reg; inw_next = inw_reg; prevv_next = prevv_reg;
        laste_next = laste_reg; lastop_next = lastop_reg;
        vseen_next = vseen_reg; runs_next = runs_reg;
        close_w = 1'b0; close_s = 1'b0;
        syl = runs_reg;
        if (vseen_reg == 2'd2 && laste_reg && lastop_reg && runs_reg != '0)
            syl = runs_reg - 1'b1;
        if (cmd.take_byte) begin
            if (c == rts_pkg::CHAR_PERIOD) begin
                close_w = 1'b1; close_s = 1'b1;
            end else if (c == rts_pkg::CHAR_SPACE) begin
                close_w = 1'b1; seg_next = 1'b1;
            end else begin
                seg_next = 1'b1; inw_next = 1'b1;
                if (is_vowel) begin
                    if (vseen_reg != 2'd2) vseen_next = vseen_reg + 2'd1;
                    lastop_next = !prevv_reg;
                    if (!prevv_reg && runs_reg != RUNS_MAX)
                        runs_next = runs_reg + 1'b1;
                    laste_next = (c == rts_pkg::CHAR_E);
                    prevv_next = 1'b1;
                end else begin
                    prevv_next = 1'b0;
                end
            end
        end
        if (cmd.close_text) begin
            close_w = 1'b1; close_s = 1'b1;
        end
        if (close_w) begin
            if (inw_reg) begin
                word_next = sat_inc(word_reg, CB'(1));
                if (syl != '0) begin
                    scored_next = sat_inc(scored_reg, CB'(1));
                    syl_next = sat_inc(syl_reg, CB'(syl));
                end
            end
            inw_next = 1'b0; vseen_next = 2'd0; runs_next = '0;
            prevv_next = 1'b0; laste_next = 1'b0; lastop_next = 1'b0;
        end
        if (close_s) begin
            if (seg_next)
                sent_next = sat_inc(sent_reg, CB'(1));
            seg_next = 1'b0;
        end
        if (cmd.clear) begin
            sent_next = '0; word_next = '0; scored_next = '0; syl_next = '0;
            seg_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sent_reg <= '0; word_reg <= '0; scored_reg <= '0; syl_reg <= '0;
            seg_reg <= 1'b0; inw_reg <= 1'b0; prevv_reg <= 1'b0;
            laste_reg <= 1'b0; lastop_reg <= 1'b0; vseen_reg <= 2'd0;
            runs_reg <= '0;
        end else begin
            sent_reg <= sent_next; word_reg <= word_next;
            scored_reg <= scored_next; syl_reg <= syl_next;
            seg_reg <= seg_next; inw_reg <= inw_next; prevv_reg <= prevv_next;
            laste_reg <= laste_next; lastop_reg <= lastop_next;
            vseen_reg <= vseen_next; runs_reg <= runs_next;
        end
    end

    // Restoring divider, one quotient bit per cycle, numerator = count << 16.
    logic [CB+1:0] trial;
    logic [31:0]   quo32;
    always_comb
    begin
        trial = {drem_reg, dnum_reg[QB-1]} - {2'b00, dden_reg};
        quo32 = (dden_reg == '0) ? 32'd0 :
                ((dnum_reg >> 32) != '0) ? 32'hFFFF_FFFF : dnum_reg[31:0];
    end

    logic [51:0] pwf_reg, psf_reg;

    // Score sum: products are Q16.16 times Q4.16 constants, 52 bits max each.
    logic [52:0] acc;
    logic signed [37:0] score;
    always_comb
    begin
        acc = 53'(pwf_reg) + 53'(psf_reg) + 53'd32768;
        score = 38'(acc >> 16) - 38'(rts_pkg::K_OFS);
    end

    // The averages times the scoring constants, 32 by 20 bits each.
    logic [51:0] mw, ms;
    assign mw = 52'(wps_reg) * 52'(rts_pkg::K_WPS);
    assign ms = 52'(spw_reg) * 52'(rts_pkg::K_SPW);

    always_ff @(posedge clk)
    begin
        if (cmd.div_start) begin
            dnum_reg <= {(cmd.div_sel ? syl_reg : word_reg), 16'd0};
            dden_reg <= cmd.div_sel ? scored_reg : sent_reg;
            drem_reg <= '0;
        end else if (cmd.div_step) begin
            if (!trial[CB+1]) begin
                drem_reg <= trial[CB:0];
                dnum_reg <= {dnum_reg[QB-2:0], 1'b1};
            end else begin
                drem_reg <= {drem_reg[CB-1:0], dnum_reg[QB-1]};
                dnum_reg <= {dnum_reg[QB-2:0], 1'b0};
            end
        end
        if (cmd.div_store) begin
            if (cmd.div_sel) spw_reg <= quo32;
            else             wps_reg <= quo32;
        end
        if (cmd.score_mul) begin
            pwf_reg <= mw;
            psf_reg <= ms;
        end
        if (cmd.score_fin) begin
            result_reg.sentence_total     <= sat32(sent_reg);
            result_reg.word_total         <= sat32(word_reg);
            result_reg.scored_word_total  <= sat32(scored_reg);
            result_reg.syllable_total     <= sat32(syl_reg);
            result_reg.words_per_sentence <= wps_reg;
            result_reg.syllables_per_word <= spw_reg;
            result_reg.divide_fault <= (sent_reg == '0) || (scored_reg == '0);
            if (score > 38'sd2147483647)
                result_reg.grade_score <= 32'sh7FFF_FFFF;
            else if (score < -38'sd2147483648)
                result_reg.grade_score <= 32'sh8000_0000;
            else
                result_reg.grade_score <= 32'(score);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.div_start)
            dcnt_reg <= DCW'(QB);
        else if (cmd.div_step && dcnt_reg != '0)
            dcnt_reg <= dcnt_reg - 1'b1;
    end

    assign sts.div_done = (dcnt_reg == '0);
    assign result = result_reg;
endmodule

>>> hdl/rts_ctrl.sv
// Controller state machine for the readability statistics block.
// Depends on rts_pkg; drives rts_datapath through rts_cmd_t.
module rts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  rts_pkg::rts_sts_t sts,
    output rts_pkg::rts_cmd_t cmd
);
    typedef enum logic [2:0] {
        S_RUN, S_CLOSE, S_DIV_W, S_DIV_S, S_MUL, S_FIN, S_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   started_reg, started_next;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        started_next = 1'b0;
        cmd = '0;
        in_ready = 1'b0;
        // A pending result leaves at its handshake in any state.
        if (out_valid_reg && out_ready) out_valid_next = 1'b0;
        case (state_reg)
            S_RUN:
            begin
                in_ready = 1'b1;
                if (in_valid && in_ready) begin
                    cmd.take_byte = 1'b1;
                    if (in_last) state_next = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                cmd.close_text = 1'b1;
                state_next = S_DIV_W;
            end
            S_DIV_W:
            begin
                cmd.div_sel = 1'b0;
                if (!started_reg) begin
                    cmd.div_start = 1'b1;
                    started_next = 1'b1;
                end else if (!sts.div_done) begin
                    cmd.div_step = 1'b1;
                    started_next = 1'b1;
                end else begin
                    cmd.div_store = 1'b1;
                    state_next = S_DIV_S;
                end
            end
            S_DIV_S:
            begin
                cmd.div_sel = 1'b1;
                if (!started_reg) begin
                    cmd.div_start = 1'b1;
                    started_next = 1'b1;
                end else if (!sts.div_done) begin
                    cmd.div_step = 1'b1;
                    started_next = 1'b1;
                end else begin
                    cmd.div_store = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.score_mul = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.score_fin = 1'b1;
                out_valid_next = 1'b1;
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                cmd.clear = 1'b1;
                state_next = S_RUN;
            end
            default: state_next = S_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_RUN;
            out_valid_reg <= 1'b0;
            started_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            started_reg <= started_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

>>> hdl/readability_text_statistics.sv
// Top level of the readability text statistics block.
// Depends on rts_pkg, rts_ctrl and rts_datapath.
//
// Usage: text enters one byte per item on the in channel (valid/ready).
// Each byte updates the sentence, word and syllable counters as it is
// taken, so ordinary bytes are taken one per clock outside the result
// sequence. The byte flagged with end_of_text starts that sequence: the
// close state first closes any open word and sentence, then two averages
// come from one shared restoring divider, one quotient bit per cycle over
// COUNT_BITS+16 bits, then one multiply stage and one saturation stage
// produce the result item on the out channel. No byte is accepted during
// the sequence nor in the clear state after it, while the counters are
// cleared. The result sits in an output register; while the receiver
// stalls, bytes of the next text are still accepted and counted, and only
// a further end of text waits. After each result all counters return to
// zero. Reset (rst_n low, asynchronous) clears all counters and drops out
// valid.
module readability_text_statistics (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rts_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rts_pkg::out_item_t out_data
);
    rts_pkg::rts_cmd_t cmd;
    rts_pkg::rts_sts_t sts;
    logic ready_int;

    // A final byte must wait while an earlier result is still pending.
    assign in_ready = ready_int && !(in_data.end_of_text && out_valid && !out_ready);

    rts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid && in_ready),
        .in_last   (in_data.end_of_text),
        .in_ready  (ready_int),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rts_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_data),
        .cmd     (cmd),
        .sts     (sts),
        .result  (out_data)
    );
endmodule
